### hw/rtl/vpc_pkg.sv
// shared types and constants for the velocity pi controller
// microcode word, datapath status, field widths and register map
// no dependencies
package vpc_pkg;

  // field widths
  localparam int unsigned KP_W    = 15;
  localparam int unsigned TI_W    = 14;
  localparam int unsigned SP_W    = 14;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned ELAP_W  = 24;
  localparam int unsigned DRIVE_W = 15;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned EOUT_W  = 16;
  localparam int unsigned PART_W  = 32;

  // internal widths
  localparam int unsigned ERR_W  = 17;  // temperature minus setpoint
  localparam int unsigned DIFF_W = 18;  // error minus last error
  localparam int unsigned M_W    = 31;  // kp times loop gain
  localparam int unsigned TIMS_W = 24;  // ti times 1000
  localparam int unsigned MUL_W  = 32;  // shared multiplier operand width
  localparam int unsigned SUM_W  = 34;  // prev drive plus both parts

  // milliseconds per second
  localparam int unsigned K_MS = 1000;

  // register reset values
  localparam logic [KP_W-1:0] KP_RST = KP_W'(256);
  localparam logic [TI_W-1:0] TI_RST = TI_W'(600);
  localparam logic [SP_W-1:0] SP_RST = SP_W'(5120);

  // register map, word index on paddr[3:2]
  localparam logic [1:0] REG_KP = 2'd0;
  localparam logic [1:0] REG_TI = 2'd1;
  localparam logic [1:0] REG_SP = 2'd2;

  typedef struct packed {
    logic [KP_W-1:0] kp;
    logic [TI_W-1:0] ti;
    logic [SP_W-1:0] setpoint;
  } cfg_t;

  // program step addresses
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT     = 4'd0;
  localparam step_t ST_ERR      = 4'd1;
  localparam step_t ST_MUL_KG   = 4'd2;
  localparam step_t ST_MUL_EE   = 4'd3;
  localparam step_t ST_MUL_DM   = 4'd4;
  localparam step_t ST_MUL_IL   = 4'd5;
  localparam step_t ST_MUL_IH   = 4'd6;
  localparam step_t ST_MUL_TI   = 4'd7;
  localparam step_t ST_LD_D     = 4'd8;
  localparam step_t ST_DIV_INIT = 4'd9;
  localparam step_t ST_DIV_STEP = 4'd10;
  localparam step_t ST_INTEG    = 4'd11;
  localparam step_t ST_SUM      = 4'd12;
  localparam step_t ST_BACK     = 4'd13;

  // datapath micro operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ERR,
    UOP_LD_M,
    UOP_LD_IE,
    UOP_LD_PROP,
    UOP_LD_NLO,
    UOP_ACC_NHI,
    UOP_LD_D,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_INTEG,
    UOP_SUM
  } uop_e;

  // multiplier operand selects
  typedef enum logic [2:0] {
    MA_ZERO,
    MA_KP,
    MA_ERRMAG,
    MA_DIFFMAG,
    MA_IELO,
    MA_IEHI,
    MA_K1000
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_ZERO,
    MB_GAIN,
    MB_ELAPSED,
    MB_M,
    MB_TI
  } mul_b_e;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEXT,
    CND_NO_IN,
    CND_TI_ZERO,
    CND_DIV_MORE,
    CND_OUT_BUSY,
    CND_ALWAYS
  } cond_e;

  typedef struct packed {
    uop_e   uop;
    mul_a_e ma;
    mul_b_e mb;
    cond_e  cond;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic ti_zero;
    logic div_more;
    logic out_busy;
  } dp_stat_t;

endpackage

### hw/rtl/vpc_seq.sv
// microcode sequencer: step counter, program rom and jump logic
// depends on vpc_pkg
module vpc_seq import vpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_stat_t stat_i,
  output ucode_t   uc_o,
  output logic     idle_o
);

  step_t  pc_q, pc_d;
  ucode_t uc;
  logic   taken;

  // program rom, one control word per step
  function automatic ucode_t rom(step_t a);
    ucode_t w;
    begin
      unique case (a)
        ST_WAIT:     w = '{UOP_NOP,      MA_ZERO,    MB_ZERO,    CND_NO_IN,    ST_WAIT};
        ST_ERR:      w = '{UOP_ERR,      MA_ZERO,    MB_ZERO,    CND_NEXT,     ST_WAIT};
        ST_MUL_KG:   w = '{UOP_NOP,      MA_KP,      MB_GAIN,    CND_NEXT,     ST_WAIT};
        ST_MUL_EE:   w = '{UOP_LD_M,     MA_ERRMAG,  MB_ELAPSED, CND_NEXT,     ST_WAIT};
        ST_MUL_DM:   w = '{UOP_LD_IE,    MA_DIFFMAG, MB_M,       CND_NEXT,     ST_WAIT};
        ST_MUL_IL:   w = '{UOP_LD_PROP,  MA_IELO,    MB_M,       CND_NEXT,     ST_WAIT};
        ST_MUL_IH:   w = '{UOP_LD_NLO,   MA_IEHI,    MB_M,       CND_NEXT,     ST_WAIT};
        ST_MUL_TI:   w = '{UOP_ACC_NHI,  MA_K1000,   MB_TI,      CND_NEXT,     ST_WAIT};
        ST_LD_D:     w = '{UOP_LD_D,     MA_ZERO,    MB_ZERO,    CND_TI_ZERO,  ST_INTEG};
        ST_DIV_INIT: w = '{UOP_DIV_INIT, MA_ZERO,    MB_ZERO,    CND_NEXT,     ST_WAIT};
        ST_DIV_STEP: w = '{UOP_DIV_STEP, MA_ZERO,    MB_ZERO,    CND_DIV_MORE, ST_DIV_STEP};
        ST_INTEG:    w = '{UOP_INTEG,    MA_ZERO,    MB_ZERO,    CND_NEXT,     ST_WAIT};
        ST_SUM:      w = '{UOP_SUM,      MA_ZERO,    MB_ZERO,    CND_OUT_BUSY, ST_SUM};
        ST_BACK:     w = '{UOP_NOP,      MA_ZERO,    MB_ZERO,    CND_ALWAYS,   ST_WAIT};
        default:     w = '{UOP_NOP,      MA_ZERO,    MB_ZERO,    CND_ALWAYS,   ST_WAIT};
      endcase
      return w;
    end
  endfunction

  assign uc = rom(pc_q);

  // jump condition select
  always_comb begin
    unique case (uc.cond)
      CND_NEXT:     taken = 1'b0;
      CND_NO_IN:    taken = !stat_i.in_fire;
      CND_TI_ZERO:  taken = stat_i.ti_zero;
      CND_DIV_MORE: taken = stat_i.div_more;
      CND_OUT_BUSY: taken = stat_i.out_busy;
      CND_ALWAYS:   taken = 1'b1;
      default:      taken = 1'b1;
    endcase
    pc_d = taken ? uc.target : pc_q + 1'b1;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uc_o   = uc;
  assign idle_o = (pc_q == ST_WAIT);

endmodule

### hw/rtl/vpc_dpath.sv
// datapath: shared 32x32 multiplier, restoring divider, error state and result register
// driven by the control word from vpc_seq; depends on vpc_pkg
module vpc_dpath import vpc_pkg::*; #(
  parameter int ELAPSED_BITS = 24,
  parameter int FRAC_BITS    = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ucode_t                   uc_i,
  input  cfg_t                     cfg_i,
  input  logic                     in_fire_i,
  input  logic signed [TEMP_W-1:0] temperature_i,
  input  logic [ELAP_W-1:0]        elapsed_ms_i,
  input  logic [DRIVE_W-1:0]       prev_drive_i,
  input  logic [GAIN_W-1:0]        loop_gain_i,
  input  logic                     out_ready_i,
  output dp_stat_t                 stat_o,
  output logic                     out_valid_o,
  output logic [DRIVE_W-1:0]       drive_o,
  output logic signed [EOUT_W-1:0] error_o,
  output logic signed [PART_W-1:0] prop_part_o,
  output logic signed [PART_W-1:0] integ_part_o,
  output logic                     clamped_o
);

  localparam int EW   = (ELAPSED_BITS < ELAP_W) ? ELAPSED_BITS : ELAP_W;
  localparam int IE_W = ERR_W + EW;
  localparam int SH   = 2 * FRAC_BITS;
  localparam int D_W  = TIMS_W + SH;
  localparam int N_W  = IE_W + M_W;
  localparam int HW   = (N_W - 32 > D_W) ? N_W - 32 : D_W;
  localparam int NX   = 32 + HW;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(31);
  localparam logic signed [SUM_W-1:0] TOP_S = SUM_W'(100 << FRAC_BITS);
  localparam logic [DRIVE_W-1:0] TOP_D = DRIVE_W'(100 << FRAC_BITS);

  // item registers
  logic signed [TEMP_W-1:0] temp_q;
  logic [EW-1:0]            elap_q;
  logic [DRIVE_W-1:0]       prev_q;
  logic [GAIN_W-1:0]        gain_q;

  // working registers
  logic signed [ERR_W-1:0]  err_q, last_err_q;
  logic                     seeded_q;
  logic [ERR_W-1:0]         errmag_q;
  logic [DIFF_W-1:0]        diffmag_q;
  logic                     diffneg_q;
  logic [M_W-1:0]           m_q;
  logic [IE_W-1:0]          ie_q;
  logic [63:0]              p_q;
  logic signed [PART_W-1:0] prop_q, integ_q;
  logic [NX-1:0]            n_q;
  logic [D_W-1:0]           d_q, rem_q;
  logic [31:0]              quo_q;
  logic                     ovf_q;
  logic [CNT_W-1:0]         cnt_q;

  // result register
  logic                     ovalid_q, ovalid_d;
  logic [DRIVE_W-1:0]       drive_q;
  logic signed [EOUT_W-1:0] eout_q;
  logic signed [PART_W-1:0] pout_q, iout_q;
  logic                     clamped_q;

  logic [MUL_W-1:0]         mul_a, mul_b;
  logic signed [ERR_W-1:0]  err_c, lerr_c;
  logic signed [DIFF_W-1:0] diff_c;
  logic [63:0]              shv_c;
  logic [D_W:0]             r2_c, sub_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic                     out_busy;

  // signed 32-bit value from sign and magnitude, saturated
  function automatic logic signed [PART_W-1:0] sat32(logic neg, logic big, logic [30:0] m);
    logic signed [PART_W-1:0] r;
    begin
      if (big) begin
        r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      end
      return r;
    end
  endfunction

  assign out_busy = ovalid_q && !out_ready_i;

  // shared multiplier operand selects
  always_comb begin
    unique case (uc_i.ma)
      MA_ZERO:    mul_a = '0;
      MA_KP:      mul_a = MUL_W'(cfg_i.kp);
      MA_ERRMAG:  mul_a = MUL_W'(errmag_q);
      MA_DIFFMAG: mul_a = MUL_W'(diffmag_q);
      MA_IELO:    mul_a = ie_q[31:0];
      MA_IEHI:    mul_a = MUL_W'(ie_q[IE_W-1:32]);
      MA_K1000:   mul_a = MUL_W'(K_MS);
      default:    mul_a = '0;
    endcase
    unique case (uc_i.mb)
      MB_ZERO:    mul_b = '0;
      MB_GAIN:    mul_b = MUL_W'(gain_q);
      MB_ELAPSED: mul_b = MUL_W'(elap_q);
      MB_M:       mul_b = MUL_W'(m_q);
      MB_TI:      mul_b = MUL_W'(cfg_i.ti);
      default:    mul_b = '0;
    endcase
  end

  // error and its difference to the last error
  always_comb begin
    err_c  = $signed({temp_q[TEMP_W-1], temp_q}) - $signed({3'b000, cfg_i.setpoint});
    lerr_c = seeded_q ? last_err_q : err_c;
    diff_c = $signed({err_c[ERR_W-1], err_c}) - $signed({lerr_c[ERR_W-1], lerr_c});
  end

  // product scaling, divider step and drive sum
  always_comb begin
    shv_c = p_q >> SH;
    r2_c  = {rem_q, quo_q[31]};
    sub_c = r2_c - {1'b0, d_q};
    sum_c = $signed({{(SUM_W-DRIVE_W){1'b0}}, prev_q}) + SUM_W'(prop_q) + SUM_W'(integ_q);
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      temp_q <= temperature_i;
      elap_q <= elapsed_ms_i[EW-1:0];
      prev_q <= prev_drive_i;
      gain_q <= loop_gain_i;
    end
  end

  // multiplier output register
  always_ff @(posedge clk_i) begin
    p_q <= 64'(mul_a) * 64'(mul_b);
  end

  // error state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      seeded_q   <= 1'b0;
    end else if (uc_i.uop == UOP_ERR) begin
      last_err_q <= err_c;
      seeded_q   <= 1'b1;
    end
  end

  // working registers, one micro operation per step
  always_ff @(posedge clk_i) begin
    unique case (uc_i.uop)
      UOP_ERR: begin
        err_q     <= err_c;
        errmag_q  <= err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
        diffmag_q <= diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
        diffneg_q <= diff_c[DIFF_W-1];
      end
      UOP_LD_M:    m_q    <= p_q[M_W-1:0];
      UOP_LD_IE:   ie_q   <= p_q[IE_W-1:0];
      UOP_LD_PROP: prop_q <= sat32(diffneg_q, |shv_c[63:31], shv_c[30:0]);
      UOP_LD_NLO:  n_q    <= NX'(p_q);
      UOP_ACC_NHI: n_q    <= n_q + (NX'(p_q) << 32);
      UOP_LD_D:    d_q    <= {p_q[TIMS_W-1:0], {SH{1'b0}}};
      UOP_DIV_INIT: begin
        ovf_q <= (n_q[NX-1:32] >= HW'(d_q));
        rem_q <= n_q[32+D_W-1:32];
        quo_q <= n_q[31:0];
        cnt_q <= '0;
      end
      UOP_DIV_STEP: begin
        if (!sub_c[D_W]) begin
          rem_q <= sub_c[D_W-1:0];
        end else begin
          rem_q <= r2_c[D_W-1:0];
        end
        quo_q <= {quo_q[30:0], !sub_c[D_W]};
        cnt_q <= cnt_q + 1'b1;
      end
      UOP_INTEG: begin
        if (cfg_i.ti == '0) begin
          integ_q <= '0;
        end else begin
          integ_q <= sat32(err_q[ERR_W-1], ovf_q || quo_q[31], quo_q[30:0]);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (uc_i.uop == UOP_SUM && !out_busy) begin
      if (sum_c < 0) begin
        drive_q   <= '0;
        clamped_q <= 1'b1;
      end else if (sum_c > TOP_S) begin
        drive_q   <= TOP_D;
        clamped_q <= 1'b1;
      end else begin
        drive_q   <= sum_c[DRIVE_W-1:0];
        clamped_q <= 1'b0;
      end
      if (err_q[ERR_W-1] != err_q[ERR_W-2]) begin
        eout_q <= err_q[ERR_W-1] ? 16'sh8000 : 16'sh7FFF;
      end else begin
        eout_q <= err_q[EOUT_W-1:0];
      end
      pout_q <= prop_q;
      iout_q <= integ_q;
    end
  end

  // result valid
  always_comb begin
    ovalid_d = ovalid_q;
    if (uc_i.uop == UOP_SUM && !out_busy) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  assign stat_o.in_fire  = in_fire_i;
  assign stat_o.ti_zero  = (cfg_i.ti == '0);
  assign stat_o.div_more = (cnt_q != DIV_LAST);
  assign stat_o.out_busy = out_busy;

  assign out_valid_o  = ovalid_q;
  assign drive_o      = drive_q;
  assign error_o      = eout_q;
  assign prop_part_o  = pout_q;
  assign integ_part_o = iout_q;
  assign clamped_o    = clamped_q;

endmodule

### hw/rtl/velocity_pi_controller_unit.sv
// Velocity-form PI controller. Each request carries a temperature, the elapsed
// milliseconds, the previous drive and a loop gain; the result is the new drive clamped to
// 0..100 percent together with the error and both change terms. A microcoded sequencer
// runs a fixed program over one shared 32x32 multiplier and a one-bit-per-cycle restoring
// divider, one request at a time. A request passes through the accepting step, the error
// and multiply steps, the divide steps and the finishing steps before the next request is
// accepted; with ti at zero the divide is skipped. A finished result waits in an output
// register, so the next request is accepted while it is pending; a result still stalled
// at the end of the next computation holds the sequencer.
// Registers (APB, word aligned): 0x0 kp, 0x4 ti, 0x8 setpoint; write them only while idle.
// Depends on vpc_pkg, vpc_seq and vpc_dpath.
module velocity_pi_controller_unit import vpc_pkg::*; #(
  parameter int ELAPSED_BITS = 24,
  parameter int FRAC_BITS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // temperature[15:0], elapsed_ms[39:16], prev_drive[54:40], loop_gain[70:55], zero[71]
  input  logic [71:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive[14:0], error[30:15], prop_part[62:31], integ_part[94:63], clamped[95]
  output logic [95:0] m_axis_tdata
);

  localparam logic [DRIVE_W-1:0] TOP_D = DRIVE_W'(100 << FRAC_BITS);

  cfg_t     cfg_q;
  ucode_t   uc;
  dp_stat_t stat;
  logic     in_fire;
  logic     apb_wr;

  logic [DRIVE_W-1:0]       drive;
  logic signed [EOUT_W-1:0] error;
  logic signed [PART_W-1:0] prop_part, integ_part;
  logic                     clamped;

  // configuration registers
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp       <= KP_RST;
      cfg_q.ti       <= TI_RST;
      cfg_q.setpoint <= SP_RST;
    end else if (apb_wr) begin
      unique case (paddr[3:2])
        REG_KP:  cfg_q.kp       <= pwdata[KP_W-1:0];
        REG_TI:  cfg_q.ti       <= pwdata[TI_W-1:0];
        REG_SP:  cfg_q.setpoint <= pwdata[SP_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_KP:  prdata = 32'(cfg_q.kp);
      REG_TI:  prdata = 32'(cfg_q.ti);
      REG_SP:  prdata = 32'(cfg_q.setpoint);
      default: prdata = '0;
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // sequencer
  vpc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uc_o   (uc),
    .idle_o (s_axis_tready)
  );

  // datapath
  vpc_dpath #(
    .ELAPSED_BITS (ELAPSED_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .uc_i          (uc),
    .cfg_i         (cfg_q),
    .in_fire_i     (in_fire),
    .temperature_i (s_axis_tdata[15:0]),
    .elapsed_ms_i  (s_axis_tdata[39:16]),
    .prev_drive_i  (s_axis_tdata[54:40]),
    .loop_gain_i   (s_axis_tdata[70:55]),
    .out_ready_i   (m_axis_tready),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .drive_o       (drive),
    .error_o       (error),
    .prop_part_o   (prop_part),
    .integ_part_o  (integ_part),
    .clamped_o     (clamped)
  );

  assign m_axis_tdata = {clamped, integ_part, prop_part, error, drive};

  // a request starts the program, so the port is busy right after it
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("request port ready right after a request");

  // integral term is disabled while ti is zero
  a_integ_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cfg_q.ti == '0) |-> (integ_part == '0))
    else $error("integral term nonzero with ti at zero");

  // a clamped drive sits on one of the two limits
  a_clamp_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && clamped) |-> (drive == '0 || drive == TOP_D))
    else $error("clamped drive not at a limit");

endmodule
